### src/tpml_pkg.sv
`timescale 1ns / 1ps
package tpml_pkg;

	localparam int NODE_FIELD_BITS = 10;
	localparam int WT_BITS         = 20;
	localparam int ST_BITS         = 2;

	// defaults for the top-level parameters
	localparam int NODE_COUNT_DEF  = 1024;
	localparam int LIFT_LEVELS_DEF = 10;
	localparam int WEIGHT_BITS_DEF = 20;

	localparam logic [WT_BITS-1:0] NO_EDGE_MIN = WT_BITS'(1000001);
	localparam logic [WT_BITS-1:0] WEIGHT_MAX  = WT_BITS'(1000000);

	localparam logic [ST_BITS-1:0] ST_ANSWER   = 2'd0;
	localparam logic [ST_BITS-1:0] ST_ATTACHED = 2'd1;
	localparam logic [ST_BITS-1:0] ST_REJECT   = 2'd2;

	localparam logic KIND_ATTACH = 1'b0;

	// one lifting row: jump target and min/max of the edges jumped over
	typedef struct packed {
		logic [NODE_FIELD_BITS-1:0] anc;
		logic [WT_BITS-1:0]         mn;
		logic [WT_BITS-1:0]         mx;
	} row_t;

endpackage

### src/tpml_lift_ram.sv
`timescale 1ns / 1ps
module tpml_lift_ram #(
	parameter int AW = 14
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     wa,
	input  tpml_pkg::row_t    wd,
	input  logic [AW-1:0]     ra,
	input  logic [AW-1:0]     rb,
	output tpml_pkg::row_t    qa,
	output tpml_pkg::row_t    qb
);
	import tpml_pkg::*;

	row_t mem [1 << AW];
	row_t qa_q, qb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		qa_q <= mem[ra];
		qb_q <= mem[rb];
	end

	assign qa = qa_q;
	assign qb = qb_q;

endmodule

### src/tree_path_min_max_lifting.sv
`timescale 1ns / 1ps
// Tree path min/max store built on binary lifting.
// Input channel (in_valid/in_ready): kind 0 attaches node_a under node_b
// (node_b 0 makes the root) with edge_weight; kind 1 asks for the min and
// max edge weight on the path between node_a and node_b.
// Output channel (out_valid/out_ready): one result per request with
// status (answered / attached / rejected), path_min and path_max.
// Sequence: an attach writes its level-0 lifting row, then does one
// lifting-row read and one write per level above 0; a query reads the
// deeper node's row per level while climbing to equal depth, then both
// nodes' rows per level from the top level down. The next request is
// taken in the cycle after the result is loaded: one request at a time.
// Reset: after arst_n releases, a clearing pass zeroes the level memory,
// one entry per cycle over NODE_COUNT entries, capped at 1024; in_ready stays
// low during it. Lifting rows need no clearing: only rows of attached
// nodes are ever read.
// Stall: a finished result sits in the output register; the block may take
// the next request meanwhile and holds its next result until that drains.
module tree_path_min_max_lifting #(
	parameter int NODE_COUNT  = tpml_pkg::NODE_COUNT_DEF,
	parameter int LIFT_LEVELS = tpml_pkg::LIFT_LEVELS_DEF,
	parameter int WEIGHT_BITS = tpml_pkg::WEIGHT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [tpml_pkg::NODE_FIELD_BITS-1:0] node_a,
	input  logic [tpml_pkg::NODE_FIELD_BITS-1:0] node_b,
	input  logic [tpml_pkg::WT_BITS-1:0]         edge_weight,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tpml_pkg::ST_BITS-1:0]         status,
	output logic [tpml_pkg::WT_BITS-1:0]         path_min,
	output logic [tpml_pkg::WT_BITS-1:0]         path_max
);
	import tpml_pkg::*;

	// node ids come from a 10-bit field, so storage never exceeds 1024 nodes
	localparam int NODES = (NODE_COUNT > 1024) ? 1024 : NODE_COUNT;
	localparam int NIDX  = $clog2(NODES);
	localparam int LVB   = $clog2(LIFT_LEVELS);
	localparam int PW    = $clog2(LIFT_LEVELS + 1);
	localparam int LVW   = LIFT_LEVELS + 1;
	localparam int AW    = NIDX + LVB;
	localparam logic [NODE_FIELD_BITS:0] NODE_LIM = (NODE_FIELD_BITS + 1)'(NODES);
	localparam logic [LVW-1:0] DEPTH_MAX = LVW'(1) << LIFT_LEVELS;
	localparam logic [PW-1:0]  P_LAST    = PW'(LIFT_LEVELS - 1);
	localparam logic [PW-1:0]  P_END     = PW'(LIFT_LEVELS);
	localparam logic [NIDX-1:0] CLR_LAST = NIDX'(NODES - 1);
	localparam logic [WT_BITS-1:0] WMASK = (WEIGHT_BITS >= WT_BITS) ? '1 :
		WT_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);

	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_DEC   = 12'b000000000100,
		S_AT_RD = 12'b000000001000,
		S_AT_WR = 12'b000000010000,
		S_Q1    = 12'b000000100000,
		S_Q1_WT = 12'b000001000000,
		S_Q2_RD = 12'b000010000000,
		S_Q2_WT = 12'b000100000000,
		S_Q3_RD = 12'b001000000000,
		S_Q3_WT = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	function automatic logic in_rng(input logic [NODE_FIELD_BITS-1:0] n);
		return {1'b0, n} < NODE_LIM;
	endfunction

	function automatic logic [WT_BITS-1:0] wmin(input logic [WT_BITS-1:0] x,
		input logic [WT_BITS-1:0] y);
		return (x < y) ? x : y;
	endfunction

	function automatic logic [WT_BITS-1:0] wmax(input logic [WT_BITS-1:0] x,
		input logic [WT_BITS-1:0] y);
		return (x > y) ? x : y;
	endfunction

	state_t state_q;
	logic   root_q;
	logic [NIDX-1:0] clr_q;

	// request and working registers
	logic                       kind_q;
	logic [NODE_FIELD_BITS-1:0] a_q, b_q;
	logic [WT_BITS-1:0]         w_q;
	logic [PW-1:0]              p_q;
	logic [LVW-1:0]             diff_q;
	logic [WT_BITS-1:0]         mn_q, mx_q;
	logic [ST_BITS-1:0]         st_q;
	row_t                       cur_q;

	// output register
	logic                 out_valid_q;
	logic [ST_BITS-1:0]   status_q;
	logic [WT_BITS-1:0]   path_min_q, path_max_q;

	// level memory: 0 means unattached, root is level 1
	logic [LVW-1:0] level_mem [NODES];
	logic [LVW-1:0] lva_q, lvb_q;
	logic           lvl_we;
	logic [NIDX-1:0] lvl_wa, lvl_ra, lvl_rb;
	logic [LVW-1:0] lvl_wd;

	// lifting memory ports
	logic          lift_we;
	logic [AW-1:0] lift_wa, lift_ra, lift_rb;
	row_t          lift_wd, rd_a, rd_b;

	logic [WT_BITS-1:0] w_in;
	logic               accept;
	row_t               row_new;
	logic               q2_move;
	logic               q_reject;
	logic               load_res;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign w_in     = ((edge_weight & WMASK) > WEIGHT_MAX) ? WEIGHT_MAX :
		(edge_weight & WMASK);

	// query on node 0, an out-of-range node or an unattached node
	assign q_reject = a_q == '0 || b_q == '0 || !in_rng(a_q) || !in_rng(b_q) ||
		lva_q == '0 || lvb_q == '0;

	// result moves to the output register once the old one is gone
	assign load_res = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// next lifting row of an attach: beyond the root the jump stays at 0
	always_comb begin
		if (cur_q.anc == '0 || !in_rng(cur_q.anc)) begin
			row_new = '{anc: '0, mn: cur_q.mn, mx: cur_q.mx};
		end else begin
			row_new = '{anc: rd_a.anc, mn: wmin(cur_q.mn, rd_a.mn),
				mx: wmax(cur_q.mx, rd_a.mx)};
		end
	end

	assign q2_move = (rd_a.anc != rd_b.anc) && (rd_a.anc != '0) && (rd_b.anc != '0) &&
		in_rng(rd_a.anc) && in_rng(rd_b.anc);

	// memory addressing
	always_comb begin
		lvl_ra  = node_a[NIDX-1:0];
		lvl_rb  = node_b[NIDX-1:0];
		lvl_we  = 1'b0;
		lvl_wa  = a_q[NIDX-1:0];
		lvl_wd  = '0;
		lift_we = 1'b0;
		lift_wa = {a_q[NIDX-1:0], p_q[LVB-1:0]};
		lift_wd = row_new;
		lift_ra = {a_q[NIDX-1:0], p_q[LVB-1:0]};
		lift_rb = {b_q[NIDX-1:0], p_q[LVB-1:0]};
		case (state_q)
			S_CLEAR: begin
				lvl_we = 1'b1;
				lvl_wa = clr_q;
			end
			S_DEC: begin
				if (kind_q == KIND_ATTACH && a_q != '0 && in_rng(a_q) && lva_q == '0) begin
					if (b_q == '0 && !root_q) begin
						lvl_we  = 1'b1;
						lvl_wd  = LVW'(1);
						lift_we = 1'b1;
						lift_wa = {a_q[NIDX-1:0], LVB'(0)};
						lift_wd = '0;
					end else if (b_q != '0 && in_rng(b_q) && lvb_q != '0 &&
						lvb_q != DEPTH_MAX) begin
						lvl_we  = 1'b1;
						lvl_wd  = lvb_q + LVW'(1);
						lift_we = 1'b1;
						lift_wa = {a_q[NIDX-1:0], LVB'(0)};
						lift_wd = '{anc: b_q, mn: w_q, mx: w_q};
					end
				end
			end
			S_AT_RD: begin
				lift_ra = {cur_q.anc[NIDX-1:0], LVB'(p_q - PW'(1))};
			end
			S_AT_WR: begin
				lift_we = 1'b1;
			end
			S_Q1: begin
				lift_ra = {b_q[NIDX-1:0], p_q[LVB-1:0]};
			end
			S_Q3_RD: begin
				lift_ra = {a_q[NIDX-1:0], LVB'(0)};
				lift_rb = {b_q[NIDX-1:0], LVB'(0)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			level_mem[lvl_wa] <= lvl_wd;
		end
		lva_q <= level_mem[lvl_ra];
		lvb_q <= level_mem[lvl_rb];
	end

	tpml_lift_ram #(
		.AW(AW)
	) u_lift_ram (
		.clk(clk),
		.we (lift_we),
		.wa (lift_wa),
		.wd (lift_wd),
		.ra (lift_ra),
		.rb (lift_rb),
		.qa (rd_a),
		.qb (rd_b)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			root_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NIDX'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (lvl_we) begin
						if (b_q == '0) begin
							root_q <= 1'b1;
						end
						state_q <= S_AT_RD;
					end else if (kind_q == KIND_ATTACH) begin
						state_q <= S_DONE;
					end else if (q_reject) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_Q1;
					end
				end
				S_AT_RD: state_q <= S_AT_WR;
				S_AT_WR: begin
					state_q <= (p_q == P_LAST) ? S_DONE : S_AT_RD;
				end
				S_Q1: begin
					if (diff_q == '0 || p_q == P_END) begin
						state_q <= (a_q != b_q && a_q != '0 && b_q != '0) ? S_Q2_RD : S_DONE;
					end else if (diff_q[0]) begin
						state_q <= S_Q1_WT;
					end
				end
				S_Q1_WT: state_q <= S_Q1;
				S_Q2_RD: state_q <= S_Q2_WT;
				S_Q2_WT: state_q <= (p_q == '0) ? S_Q3_RD : S_Q2_RD;
				S_Q3_RD: state_q <= S_Q3_WT;
				S_Q3_WT: state_q <= S_DONE;
				S_DONE: begin
					if (load_res) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers (no reset needed)
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= kind;
					a_q    <= node_a;
					b_q    <= node_b;
					w_q    <= w_in;
				end
			end
			S_DEC: begin
				cur_q <= lift_wd;
				if (lvl_we) begin
					st_q <= ST_ATTACHED;
					mn_q <= '0;
					mx_q <= '0;
					p_q  <= PW'(1);
				end else if (kind_q == KIND_ATTACH || q_reject) begin
					st_q <= ST_REJECT;
					mn_q <= '0;
					mx_q <= '0;
					p_q  <= PW'(1);
				end else begin
					st_q <= ST_ANSWER;
					mn_q <= NO_EDGE_MIN;
					mx_q <= '0;
					p_q  <= '0;
					if (lva_q > lvb_q) begin
						a_q    <= b_q;
						b_q    <= a_q;
						diff_q <= lva_q - lvb_q;
					end else begin
						diff_q <= lvb_q - lva_q;
					end
				end
			end
			S_AT_WR: begin
				cur_q <= row_new;
				p_q   <= p_q + PW'(1);
			end
			S_Q1: begin
				if (diff_q == '0 || p_q == P_END) begin
					p_q <= P_LAST;
				end else if (!diff_q[0]) begin
					diff_q <= diff_q >> 1;
					p_q    <= p_q + PW'(1);
				end
			end
			S_Q1_WT: begin
				mn_q   <= wmin(mn_q, rd_a.mn);
				mx_q   <= wmax(mx_q, rd_a.mx);
				b_q    <= in_rng(rd_a.anc) ? rd_a.anc : '0;
				diff_q <= diff_q >> 1;
				p_q    <= p_q + PW'(1);
			end
			S_Q2_WT: begin
				if (q2_move) begin
					mn_q <= wmin(mn_q, wmin(rd_a.mn, rd_b.mn));
					mx_q <= wmax(mx_q, wmax(rd_a.mx, rd_b.mx));
					a_q  <= rd_a.anc;
					b_q  <= rd_b.anc;
				end
				if (p_q != '0) begin
					p_q <= p_q - PW'(1);
				end
			end
			S_Q3_WT: begin
				mn_q <= wmin(mn_q, wmin(rd_a.mn, rd_b.mn));
				mx_q <= wmax(mx_q, wmax(rd_a.mx, rd_b.mx));
			end
			S_DONE: begin
				if (load_res) begin
					status_q   <= st_q;
					path_min_q <= mn_q;
					path_max_q <= mx_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign path_min  = path_min_q;
	assign path_max  = path_max_q;

	// no request taken while the level memory is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready)
		else $error("request accepted during clearing pass");

	// only answered requests carry path weights
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ANSWER |-> path_min == '0 && path_max == '0)
		else $error("non-answer result with nonzero weights");

	// status is always one of the three codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_ANSWER || status == ST_ATTACHED || status == ST_REJECT)
		else $error("bad status code");

	// a waiting result is not overwritten by the next one
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(path_min))
		else $error("stalled result changed");

endmodule

### tb/tree_path_min_max_lifting_tb.sv
`timescale 1ns / 1ps
module tree_path_min_max_lifting_tb;
	import tpml_pkg::*;

	localparam int NODES  = NODE_COUNT_DEF;
	localparam int LEVELS = LIFT_LEVELS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [ST_BITS-1:0] st;
		logic [WT_BITS-1:0] mn;
		logic [WT_BITS-1:0] mx;
	} answer_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic kind;
	logic [NODE_FIELD_BITS-1:0] node_a;
	logic [NODE_FIELD_BITS-1:0] node_b;
	logic [WT_BITS-1:0] edge_weight;
	logic out_valid;
	logic out_ready;
	logic [ST_BITS-1:0] status;
	logic [WT_BITS-1:0] path_min;
	logic [WT_BITS-1:0] path_max;

	// predictor state: levels and lifting rows per node
	int unsigned lvl_of[NODES];
	int unsigned up_node[NODES][LEVELS];
	int unsigned up_min[NODES][LEVELS];
	int unsigned up_max[NODES][LEVELS];
	bit has_root;
	int unsigned attached[$];   // attached node list, for picking parents

	answer_t pending_answers[$];
	int error_count;
	int idle_cycles;
	bit hold_off;               // long receiver stall request
	bit mark_rand_gap;          // sender bursts on/off

	tree_path_min_max_lifting DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .node_a(node_a), .node_b(node_b), .edge_weight(edge_weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .path_min(path_min), .path_max(path_max)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned wmin(int unsigned x, int unsigned y);
		return x < y ? x : y;
	endfunction

	function automatic int unsigned wmax(int unsigned x, int unsigned y);
		return x > y ? x : y;
	endfunction

	// apply one attach to the local tables, return the predicted response
	function automatic answer_t predict_attach(int unsigned child, int unsigned par,
			int unsigned w);
		answer_t r;
		int unsigned mid;
		r = '{st: ST_REJECT, mn: '0, mx: '0};
		if (child == 0 || lvl_of[child] != 0)
			return r;
		if (par == 0) begin
			if (has_root)
				return r;
			has_root = 1'b1;
			lvl_of[child] = 1;
			for (int p = 0; p < LEVELS; p++) begin
				up_node[child][p] = 0;
				up_min[child][p] = 0;
				up_max[child][p] = 0;
			end
		end else begin
			if (lvl_of[par] == 0 || lvl_of[par] + 1 > (1 << LEVELS))
				return r;
			lvl_of[child] = lvl_of[par] + 1;
			up_node[child][0] = par;
			up_min[child][0] = w;
			up_max[child][0] = w;
			for (int p = 1; p < LEVELS; p++) begin
				mid = up_node[child][p-1];
				if (mid == 0) begin
					up_node[child][p] = 0;
					up_min[child][p] = up_min[child][p-1];
					up_max[child][p] = up_max[child][p-1];
				end else begin
					up_node[child][p] = up_node[mid][p-1];
					up_min[child][p] = wmin(up_min[child][p-1], up_min[mid][p-1]);
					up_max[child][p] = wmax(up_max[child][p-1], up_max[mid][p-1]);
				end
			end
		end
		attached = {attached, child};
		r.st = ST_ATTACHED;
		return r;
	endfunction

	function automatic answer_t predict_query(int unsigned a, int unsigned b);
		answer_t r;
		int unsigned mn, mx, diff, t, ua, ub;
		r = '{st: ST_REJECT, mn: '0, mx: '0};
		if (a == 0 || b == 0 || lvl_of[a] == 0 || lvl_of[b] == 0)
			return r;
		mn = 1000001;
		mx = 0;
		if (lvl_of[a] > lvl_of[b]) begin
			t = a;
			a = b;
			b = t;
		end
		diff = lvl_of[b] - lvl_of[a];
		for (int p = 0; p < LEVELS && diff != 0; p++) begin
			if (diff[0]) begin
				mn = wmin(mn, up_min[b][p]);
				mx = wmax(mx, up_max[b][p]);
				b = up_node[b][p];
			end
			diff = diff >> 1;
		end
		if (a != b && a != 0 && b != 0) begin
			for (int p = LEVELS - 1; p >= 0; p--) begin
				ua = up_node[a][p];
				ub = up_node[b][p];
				if (ua != ub && ua != 0 && ub != 0) begin
					mn = wmin(mn, wmin(up_min[a][p], up_min[b][p]));
					mx = wmax(mx, wmax(up_max[a][p], up_max[b][p]));
					a = ua;
					b = ub;
				end
			end
			mn = wmin(mn, wmin(up_min[a][0], up_min[b][0]));
			mx = wmax(mx, wmax(up_max[a][0], up_max[b][0]));
		end
		r.st = ST_ANSWER;
		r.mn = WT_BITS'(mn);
		r.mx = WT_BITS'(mx);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_v);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
		error_count++;
	endtask

	// send one request; the prediction is queued at acceptance
	task automatic send_request(input logic k, input int unsigned a, input int unsigned b,
			input int unsigned w);
		int unsigned wsat;
		answer_t exp_r;
		while (mark_rand_gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		node_a <= a[NODE_FIELD_BITS-1:0];
		node_b <= b[NODE_FIELD_BITS-1:0];
		edge_weight <= w[WT_BITS-1:0];
		do
			@(posedge clk);
		while (!in_ready);
		wsat = w[WT_BITS-1:0];
		if (wsat > WEIGHT_MAX)
			wsat = WEIGHT_MAX;
		if (k == KIND_ATTACH)
			exp_r = predict_attach(a[NODE_FIELD_BITS-1:0], b[NODE_FIELD_BITS-1:0], wsat);
		else
			exp_r = predict_query(a[NODE_FIELD_BITS-1:0], b[NODE_FIELD_BITS-1:0]);
		pending_answers = {pending_answers, exp_r};
	endtask

	function automatic int unsigned pick_node();
		if (attached.size() == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 1023);
		return attached[$urandom_range(0, attached.size() - 1)];
	endfunction

	function automatic int unsigned pick_weight();
		case ($urandom_range(0, 9))
			0: return $urandom_range(1000001, 1048575);   // saturates
			1: return 0;
			2: return 1000000;
			default: return $urandom_range(0, 1000000);
		endcase
	endfunction

	// response monitor
	always @(posedge clk) begin
		answer_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected response, status", status, 0);
			end else begin
				exp_r = pending_answers.pop_front();
				if (status !== exp_r.st)
					report_mismatch("status", status, exp_r.st);
				if (path_min !== exp_r.mn)
					report_mismatch("path_min", path_min, exp_r.mn);
				if (path_max !== exp_r.mx)
					report_mismatch("path_max", path_max, exp_r.mx);
			end
		end
	end

	// receiver: own stall pattern, plus the long hold-off when asked
	always @(posedge clk) begin
		int unsigned phase;
		phase = ($realtime / 10);
		if (hold_off)
			out_ready <= 1'b0;
		else if ((phase / 64) % 3 == 0)
			out_ready <= 1'b1;          // stretch without stalls
		else
			out_ready <= ($urandom_range(0, 2) != 0);
	end

	// sender bursts: random gap lengths between random-length bursts
	initial begin
		mark_rand_gap = 1'b0;
		forever begin
			repeat ($urandom_range(1, 40)) @(posedge clk);
			mark_rand_gap <= ($urandom_range(0, 2) == 0);
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_directed();
		// query and attach before any root
		send_request(1'b1, 1, 2, 0);
		send_request(1'b0, 5, 7, 10);        // parent unattached
		send_request(1'b0, 0, 0, 10);        // child 0
		send_request(1'b0, 1, 0, 1048575);   // root, weight ignored
		send_request(1'b0, 9, 0, 5);         // second root
		send_request(1'b0, 1, 0, 5);         // already attached
		send_request(1'b0, 2, 1, 1048575);   // saturated weight
		send_request(1'b0, 3, 1, 0);
		send_request(1'b0, 1023, 2, 1000000);
		send_request(1'b0, 4, 3, 17);
		send_request(1'b0, 5, 4, 16);
		send_request(1'b1, 1023, 5, 0);
		send_request(1'b1, 5, 1023, 0);
		send_request(1'b1, 4, 4, 0);         // equal nodes
		send_request(1'b1, 1, 5, 0);
		send_request(1'b1, 0, 5, 0);
		send_request(1'b1, 5, 600, 0);       // unattached
		send_request(1'b1, 1023, 1023, 0);
	endtask

	// a long chain reaches deep levels; the level limit sits beyond 1024 nodes
	task automatic test_deep_chain();
		int unsigned prev;
		prev = 5;
		for (int n = 6; n < 140; n++) begin
			send_request(1'b0, n, prev, $urandom_range(0, 1000000));
			prev = n;
		end
		for (int i = 0; i < 30; i++)
			send_request(1'b1, $urandom_range(1, 139), $urandom_range(1, 139), 0);
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 650; i++) begin
			if ($urandom_range(0, 2) == 0)
				send_request(1'b0, $urandom_range(0, 1023), pick_node(), pick_weight());
			else
				send_request(1'b1, pick_node(), pick_node(), pick_weight());
		end
	endtask

	// receiver holds off while requests keep coming so the input stalls
	task automatic test_output_stall();
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 20; i++)
				send_request(1'b1, pick_node(), pick_node(), 0);
		join
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		node_a = '0;
		node_b = '0;
		edge_weight = '0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		has_root = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		for (int i = 0; i < NODES; i++)
			lvl_of[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_deep_chain();
		test_output_stall();
		test_random_mix();
		in_valid <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
